// ===== sv/usvr_pkg.sv =====
// Shared types, request codes and constants of the vendor request responder.
// No dependencies.
package usvr_pkg;

  localparam int EepromWordsDefault = 64;
  localparam logic [24:0] RateIdle = 25'd1200;
  localparam logic [24:0] RateDivOne = 25'd2000000;
  localparam logic [24:0] RateDivZero = 25'd3000000;
  localparam logic [25:0] UsbClkHz = 26'd48000000;
  localparam logic [7:0] LatencyBusReset = 8'h10;
  localparam logic [7:0] LatencyReset = 8'h04;

  localparam logic [7:0] CmdReset = 8'h00;
  localparam logic [7:0] CmdModem = 8'h01;
  localparam logic [7:0] CmdFlow = 8'h02;
  localparam logic [7:0] CmdBaud = 8'h03;
  localparam logic [7:0] CmdData = 8'h04;
  localparam logic [7:0] CmdPoll = 8'h05;
  localparam logic [7:0] CmdEvent = 8'h06;
  localparam logic [7:0] CmdError = 8'h07;
  localparam logic [7:0] CmdSetLat = 8'h09;
  localparam logic [7:0] CmdGetLat = 8'h0A;
  localparam logic [7:0] CmdBitMode = 8'h0B;
  localparam logic [7:0] CmdEeprom = 8'h90;

  localparam logic [1:0] StatAck = 2'd0;
  localparam logic [1:0] StatData = 2'd1;
  localparam logic [1:0] StatStall = 2'd2;

  typedef enum logic [2:0] {
    OP_DONE = 3'b001,
    OP_BAUD = 3'b010,
    OP_DATA = 3'b100
  } op_t;

  // classified beat handed from front to back
  typedef struct packed {
    op_t         op;
    logic [1:0]  status;
    logic [1:0]  resp_len;
    logic [15:0] resp_data;
    logic        eeprom_read;
    logic [5:0]  eeprom_addr;
    logic        dtr_level;
    logic        rts_level;
    logic [15:0] value;
    logic [23:0] composite;
  } job_t;

  function automatic logic [3:0] frac_code(input logic [2:0] c);
    case (c)
      3'd0: frac_code = 4'd0;
      3'd1: frac_code = 4'd8;
      3'd2: frac_code = 4'd4;
      3'd3: frac_code = 4'd2;
      3'd4: frac_code = 4'd6;
      3'd5: frac_code = 4'd10;
      3'd6: frac_code = 4'd12;
      default: frac_code = 4'd14;
    endcase
  endfunction

endpackage

// ===== sv/usb_serial_vendor_request_responder.sv =====
// Top level of the vendor request responder: front, queue, back.
// Depends on usvr_pkg, usvr_front, usvr_fifo, usvr_back.
// One result per request, in order. A baud request with a general divisor
// passes through the one-bit-per-cycle restoring division of 48 MHz by
// the 18-bit divisor; other requests skip it.
module usb_serial_vendor_request_responder
  import usvr_pkg::*;
#(
  parameter int EEPROM_WORDS = EepromWordsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  cmd,
  input  logic [15:0] value,
  input  logic [15:0] index,
  input  logic        bus_reset,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status,
  output logic [1:0]  resp_len,
  output logic [15:0] resp_data,
  output logic        eeprom_read,
  output logic [5:0]  eeprom_addr,
  output logic        dtr_level,
  output logic        rts_level,
  output logic        line_update,
  output logic [24:0] baud_rate,
  output logic [7:0]  data_bits,
  output logic [7:0]  parity_raw,
  output logic [4:0]  stop_raw
);

  logic f_valid, f_ready, b_valid, b_ready;
  job_t f_job, b_job;

  usvr_front #(.EEPROM_WORDS(EEPROM_WORDS)) u_front (
    .clk, .rst, .push, .full, .cmd, .value, .index, .bus_reset,
    .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
  );

  usvr_fifo u_fifo (
    .clk, .rst, .in_valid(f_valid), .in_ready(f_ready), .in_job(f_job),
    .out_valid(b_valid), .out_ready(b_ready), .out_job(b_job)
  );

  usvr_back u_back (
    .clk, .rst, .job_valid(b_valid), .job_ready(b_ready), .job(b_job),
    .empty, .pop, .status, .resp_len, .resp_data, .eeprom_read, .eeprom_addr,
    .dtr_level, .rts_level, .line_update, .baud_rate, .data_bits,
    .parity_raw, .stop_raw
  );

`ifndef SYNTHESIS
  a_upd_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && !line_update |-> baud_rate == '0 && data_bits == '0)
    else $error("rate without update");
  a_eeprom: assert property (@(posedge clk) disable iff (rst)
    !empty && eeprom_read |-> status == StatData && resp_len == 2'd2)
    else $error("eeprom beat malformed");
  a_reset_empty: assert property (@(posedge clk) !rst && $past(rst) |-> empty)
    else $error("result after reset");
`endif

endmodule

// ===== sv/usvr_front.sv =====
// Front end: accepts requests, keeps latency and modem lines, classifies beats.
// Depends on usvr_pkg.
module usvr_front
  import usvr_pkg::*;
#(
  parameter int EEPROM_WORDS = EepromWordsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  cmd,
  input  logic [15:0] value,
  input  logic [15:0] index,
  input  logic        bus_reset,
  output logic        job_valid,
  input  logic        job_ready,
  output job_t        job
);

  localparam int AddrW = $clog2(EEPROM_WORDS);

  logic [7:0] latency_port_a, latency_port_b;
  logic dtr_line, rts_line;
  logic acc;
  job_t j;
  logic [7:0] port;

  assign full = job_valid && !job_ready;
  assign acc = push && !full;
  assign port = index[7:0];

  always_comb begin
    j = '0;
    j.op = OP_DONE;
    j.value = value;
    j.composite = {index[15:8], value};
    j.dtr_level = dtr_line;
    j.rts_level = rts_line;
    if (!bus_reset) begin
      case (cmd)
        CmdEeprom: begin
          j.status = StatData;
          j.resp_len = 2'd2;
          j.eeprom_read = 1'b1;
          j.eeprom_addr = 6'(port[AddrW-1:0]);
        end
        CmdReset, CmdFlow, CmdEvent, CmdError, CmdBitMode: ;
        CmdModem: begin
          if (value == 16'h0101) j.dtr_level = 1'b1;
          else if (value == 16'h0100) j.dtr_level = 1'b0;
          else if (value == 16'h0202) j.rts_level = 1'b1;
          else if (value == 16'h0200) j.rts_level = 1'b0;
        end
        CmdBaud: j.op = OP_BAUD;
        CmdData: j.op = OP_DATA;
        CmdPoll: begin
          j.status = StatData;
          j.resp_len = 2'd2;
          j.eeprom_read = 1'b1;
          j.eeprom_addr = 6'd2;
        end
        CmdSetLat: ;
        CmdGetLat: begin
          j.status = StatData;
          j.resp_len = 2'd1;
          j.resp_data = {8'd0, (port == 8'd1) ? latency_port_a : latency_port_b};
        end
        default: j.status = StatStall;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latency_port_a <= LatencyReset;
      latency_port_b <= LatencyReset;
      dtr_line <= 1'b0;
      rts_line <= 1'b0;
      job_valid <= 1'b0;
    end else begin
      if (acc) job_valid <= 1'b1;
      else if (job_ready) job_valid <= 1'b0;
      if (acc) begin
        job <= j;
        dtr_line <= j.dtr_level;
        rts_line <= j.rts_level;
        if (bus_reset) begin
          latency_port_a <= LatencyBusReset;
          latency_port_b <= LatencyBusReset;
        end else if (cmd == CmdSetLat) begin
          if (port == 8'd1) latency_port_a <= value[7:0];
          else latency_port_b <= value[7:0];
        end
      end
    end
  end

endmodule

// ===== sv/usvr_back.sv =====
// Back end: baud decode with a serial restoring divider, result register.
// Depends on usvr_pkg.
module usvr_back
  import usvr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  output logic        job_ready,
  input  job_t        job,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status,
  output logic [1:0]  resp_len,
  output logic [15:0] resp_data,
  output logic        eeprom_read,
  output logic [5:0]  eeprom_addr,
  output logic        dtr_level,
  output logic        rts_level,
  output logic        line_update,
  output logic [24:0] baud_rate,
  output logic [7:0]  data_bits,
  output logic [7:0]  parity_raw,
  output logic [4:0]  stop_raw
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_OUT  = 3'b100
  } st_t;

  st_t st;
  job_t cur;
  logic [24:0] baud_state;
  logic [17:0] dvs;
  logic [25:0] quo;
  logic [17:0] rem;
  logic [4:0] cnt;
  logic [18:0] trial;
  logic [24:0] fin_rate;

  assign trial = {rem, quo[25]};
  assign job_ready = (st == S_IDLE) && (empty || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      empty <= 1'b1;
      baud_state <= RateIdle;
    end else begin
      if (st == S_OUT && (empty || pop)) empty <= 1'b0;
      else if (pop && !empty) empty <= 1'b1;
      case (st)
        S_IDLE: begin
          if (job_valid && job_ready) begin
            cur <= job;
            if (job.op == OP_BAUD) begin
              if (job.composite == 24'd1) begin
                fin_rate <= RateDivOne;
                st <= S_OUT;
              end else if (job.composite == 24'd0) begin
                fin_rate <= RateDivZero;
                st <= S_OUT;
              end else begin
                dvs <= {job.composite[13:0], frac_code(job.composite[16:14])};
                if ({job.composite[13:0], frac_code(job.composite[16:14])} == 18'd0) begin
                  fin_rate <= '0;
                  st <= S_OUT;
                end else begin
                  quo <= UsbClkHz;
                  rem <= '0;
                  cnt <= '0;
                  st <= S_DIV;
                end
              end
            end else begin
              st <= S_OUT;
            end
          end
        end
        S_DIV: begin
          if (trial >= {1'b0, dvs}) begin
            rem <= 18'(trial - {1'b0, dvs});
            quo <= {quo[24:0], 1'b1};
          end else begin
            rem <= trial[17:0];
            quo <= {quo[24:0], 1'b0};
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'd25) st <= S_OUT;
        end
        S_OUT: begin
          if (empty || pop) begin
            st <= S_IDLE;
            status <= cur.status;
            resp_len <= cur.resp_len;
            resp_data <= cur.resp_data;
            eeprom_read <= cur.eeprom_read;
            eeprom_addr <= cur.eeprom_addr;
            dtr_level <= cur.dtr_level;
            rts_level <= cur.rts_level;
            line_update <= 1'b0;
            baud_rate <= '0;
            data_bits <= '0;
            parity_raw <= '0;
            stop_raw <= '0;
            if (cur.op == OP_BAUD) begin
              baud_state <= fin_rate;
              if (fin_rate != RateIdle) begin
                line_update <= 1'b1;
                baud_rate <= fin_rate;
                data_bits <= 8'd8;
              end
            end else if (cur.op == OP_DATA && baud_state != RateIdle) begin
              line_update <= 1'b1;
              baud_rate <= baud_state;
              data_bits <= cur.value[7:0];
              parity_raw <= cur.value[15:8];
              stop_raw <= cur.value[15:11];
            end
          end
        end
        default: st <= S_IDLE;
      endcase
      if (st == S_DIV && cnt == 5'd25)
        fin_rate <= 25'({quo[24:0], (trial >= {1'b0, dvs})});
    end
  end

endmodule

// ===== sv/usvr_fifo.sv =====
// Two-entry beat queue between front and back.
// Depends on usvr_pkg.
module usvr_fifo
  import usvr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  job_t in_job,
  output logic out_valid,
  input  logic out_ready,
  output job_t out_job
);

  job_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;
  logic wr, rd;

  assign in_ready = cnt != 2'd2;
  assign out_valid = cnt != 2'd0;
  assign out_job = mem[rp];
  assign wr = in_valid && in_ready;
  assign rd = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= in_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= '0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      cnt <= cnt + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule
